[design/srct_pkg.sv]
// ----------------------------------------------------------------------------
// srct_pkg
// Shared types and constants for the sparse row cell table.
// ----------------------------------------------------------------------------
package srct_pkg;

  localparam int ROW_COUNT_DEF     = 8;
  localparam int COLUMN_COUNT_DEF  = 8;
  localparam int SLOTS_PER_ROW_DEF = 8;

  localparam int ROW_FIELD_W    = 8;
  localparam int COLUMN_FIELD_W = 8;
  localparam int COLOR_W        = 2;

  localparam logic [COLOR_W-1:0] HIGHEST_COLOR_RESET = 2'd2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_MATCH  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t                 cmd;
    logic [ROW_FIELD_W-1:0]    row;
    logic [COLUMN_FIELD_W-1:0] column;
    logic [COLOR_W-1:0]        color;
  } request_t;

  typedef struct packed {
    logic               status;
    logic [COLOR_W-1:0] cell_color;
  } result_t;

  // Decoded command held between the row read and the write-back
  typedef struct packed {
    request_t req;
    logic     in_range;
  } stage_ctrl_t;

endpackage

[design/srct_row_mem.sv]
// ----------------------------------------------------------------------------
// srct_row_mem
// Row memory: one word per row, registered read, per-row written flags so
// that a row never written since reset reads as empty.
// ----------------------------------------------------------------------------
module srct_row_mem #(
  parameter int ROWS   = 8,
  parameter int ADDR_W = 3,
  parameter int WORD_W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  logic [WORD_W-1:0] mem [ROWS];
  logic [ROWS-1:0]   written;
  logic [WORD_W-1:0] rd_q;
  logic              rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // an unwritten row is an empty row
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

[design/srct_slot_logic.sv]
// ----------------------------------------------------------------------------
// srct_slot_logic
// Compares one row word against the command across all slots and builds
// the updated word, the write request and the result.
// ----------------------------------------------------------------------------
module srct_slot_logic #(
  parameter int SLOTS  = 8,
  parameter int COL_W  = 3,
  parameter int WORD_W = 48
) (
  input  logic [WORD_W-1:0]          word,
  input  srct_pkg::stage_ctrl_t      ctrl,
  input  logic [srct_pkg::COLOR_W-1:0] highest_color,
  output logic [WORD_W-1:0]          word_next,
  output logic                       write,
  output srct_pkg::result_t          res
);

  import srct_pkg::*;

  typedef struct packed {
    logic [SLOTS-1:0]              valid;
    logic [SLOTS-1:0][COL_W-1:0]   column;
    logic [SLOTS-1:0][COLOR_W-1:0] color;
  } row_word_t;

  row_word_t          cur;
  row_word_t          nxt;
  logic [SLOTS-1:0]   hit;
  logic [SLOTS-1:0]   free;
  logic               any_hit;
  logic               full;
  logic [COLOR_W-1:0] hit_color;
  logic [COL_W-1:0]   col;

  assign cur = word;
  assign col = ctrl.req.column[COL_W-1:0];

  always_comb begin
    hit_color = '0;
    for (int s = 0; s < SLOTS; s++) begin
      hit[s] = cur.valid[s] && (cur.column[s] == col);
      if (hit[s]) begin
        hit_color = hit_color | cur.color[s];
      end
    end
  end

  // lowest clear valid bit
  assign free    = ~cur.valid & (cur.valid + SLOTS'(1));
  assign full    = &cur.valid;
  assign any_hit = |hit;

  always_comb begin
    nxt            = cur;
    write          = 1'b0;
    res.status     = 1'b1;
    res.cell_color = '0;
    if (ctrl.in_range) begin
      case (ctrl.req.cmd)
        CMD_INSERT: begin
          if (ctrl.req.color != '0 && ctrl.req.color <= highest_color &&
              !any_hit && !full) begin
            for (int s = 0; s < SLOTS; s++) begin
              if (free[s]) begin
                nxt.valid[s]  = 1'b1;
                nxt.column[s] = col;
                nxt.color[s]  = ctrl.req.color;
              end
            end
            write      = 1'b1;
            res.status = 1'b0;
          end
        end
        CMD_DELETE: begin
          if (any_hit) begin
            for (int s = 0; s < SLOTS; s++) begin
              if (hit[s]) begin
                nxt.valid[s]  = 1'b0;
                nxt.column[s] = '0;
                nxt.color[s]  = '0;
              end
            end
            write      = 1'b1;
            res.status = 1'b0;
          end
        end
        CMD_READ: begin
          if (any_hit) begin
            res.status     = 1'b0;
            res.cell_color = hit_color;
          end
        end
        CMD_MATCH: begin
          if (any_hit && hit_color == ctrl.req.color) begin
            res.status = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign word_next = nxt;

endmodule

[design/sparse_row_cell_table.sv]
// ----------------------------------------------------------------------------
// sparse_row_cell_table
// Sparse grid stored row by row, each row a fixed set of column/colour slots.
// done strobes after the start transfer, once busy has passed on to done; no new
// command is taken while busy, for the read-modify-write of one row word in the row memory.
// busy is high for the cycle between the row read and the write-back.
// done shows for one cycle only and result holds until the next command; the receiver cannot stall it.
// Reset empties the whole table at once and sets highest_color to 2.
// ----------------------------------------------------------------------------
module sparse_row_cell_table #(
  parameter int ROW_COUNT     = srct_pkg::ROW_COUNT_DEF,
  parameter int COLUMN_COUNT  = srct_pkg::COLUMN_COUNT_DEF,
  parameter int SLOTS_PER_ROW = srct_pkg::SLOTS_PER_ROW_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  srct_pkg::request_t           request,
  input  logic                         highest_color_we,
  input  logic [srct_pkg::COLOR_W-1:0] highest_color_data,
  output logic                         done,
  output srct_pkg::result_t            result
);

  import srct_pkg::*;

  localparam int ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
  localparam int WORD_W = SLOTS_PER_ROW * (1 + COL_W + COLOR_W);

  logic               accept;
  logic               in_range;
  logic [COLOR_W-1:0] highest_color;
  stage_ctrl_t        ctrl;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  word_next;
  logic               write;
  result_t            res_next;

  assign accept   = start && !busy;
  assign in_range = (request.row < ROW_FIELD_W'(ROW_COUNT)) &&
                    (request.column < COLUMN_FIELD_W'(COLUMN_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      done          <= 1'b0;
      highest_color <= HIGHEST_COLOR_RESET;
    end else begin
      busy <= accept;
      done <= busy;
      if (highest_color_we) begin
        highest_color <= highest_color_data;
      end
    end
  end

  // hold the command while its row is read
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl.req      <= request;
      ctrl.in_range <= in_range;
    end
    if (busy) begin
      result <= res_next;
    end
  end

  srct_row_mem #(
    .ROWS   (ROW_COUNT),
    .ADDR_W (ROW_W),
    .WORD_W (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (request.row[ROW_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (busy && write),
    .wr_addr (ctrl.req.row[ROW_W-1:0]),
    .wr_data (word_next)
  );

  srct_slot_logic #(
    .SLOTS  (SLOTS_PER_ROW),
    .COL_W  (COL_W),
    .WORD_W (WORD_W)
  ) u_slots (
    .word          (rd_data),
    .ctrl          (ctrl),
    .highest_color (highest_color),
    .word_next     (word_next),
    .write         (write),
    .res           (res_next)
  );

endmodule

[design/srct_checker.sv]
// ----------------------------------------------------------------------------
// srct_checker
// Port-level timing checks of the command handshake, bound to the top level.
// ----------------------------------------------------------------------------
module srct_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("block not idle after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer not followed by busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("busy not followed by a single result");

  a_done_only: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind sparse_row_cell_table srct_checker u_srct_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
